// ===== src/caf_pkg.sv =====
// ----------------------------------------------------------------------------
// caf_pkg: shared types and constants of the complementary attitude filter
// Fixed-point widths, filter coefficients, register indexes and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package caf_pkg;

    // CORDIC datapath width: operands scaled by 2^14 plus gain and sign headroom.
    localparam int CW = 34;
    // Angle accumulator width, units of 2^-16 degree.
    localparam int ZW = 27;
    // Radicand width for the square root, (ay^2 + az^2) * 2^28.
    localparam int RAD_W = 60;
    // Root width and number of root digits.
    localparam int ROOT_W = RAD_W / 2;
    // Number of entries in the arctangent table.
    localparam int TABLE_LEN = 24;
    // Index width into the arctangent table.
    localparam int TIW = $clog2(TABLE_LEN);

    // Shared multiplier operand and product widths.
    localparam int MA_W = 34;
    localparam int MB_W = 20;
    localparam int MP_W = MA_W + MB_W;

    // 180 degrees in units of 2^-16 degree.
    localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;

    // Filter coefficients in Q16: 0.98, 0.02 and 0.01 s * 2^9.
    localparam logic signed [MB_W-1:0] ALPHA_Q16   = 20'sd64225;
    localparam logic signed [MB_W-1:0] BETA_Q16    = 20'sd1311;
    localparam logic signed [MB_W-1:0] DT_RATE_Q16 = 20'sd335544;

    // Configuration register indexes.
    typedef enum logic
    {
        REG_ROLL_BIAS  = 1'b0,
        REG_PITCH_BIAS = 1'b1
    } caf_reg_t;

    // Status of an iterative unit seen by the sequencer.
    typedef struct packed
    {
        logic busy;
        logic done;
    } caf_unit_stat_t;

    // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_entry(input logic [TIW-1:0] idx);
        logic signed [ZW-1:0] val;
        unique case (idx)
            5'd0:    val = 27'sd2949120;
            5'd1:    val = 27'sd1740967;
            5'd2:    val = 27'sd919879;
            5'd3:    val = 27'sd466945;
            5'd4:    val = 27'sd234379;
            5'd5:    val = 27'sd117304;
            5'd6:    val = 27'sd58666;
            5'd7:    val = 27'sd29335;
            5'd8:    val = 27'sd14668;
            5'd9:    val = 27'sd7334;
            5'd10:   val = 27'sd3667;
            5'd11:   val = 27'sd1833;
            5'd12:   val = 27'sd917;
            5'd13:   val = 27'sd458;
            5'd14:   val = 27'sd229;
            5'd15:   val = 27'sd115;
            5'd16:   val = 27'sd57;
            5'd17:   val = 27'sd29;
            5'd18:   val = 27'sd14;
            5'd19:   val = 27'sd7;
            5'd20:   val = 27'sd4;
            5'd21:   val = 27'sd2;
            5'd22:   val = 27'sd1;
            default: val = 27'sd0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/caf_cordic.sv =====
// ----------------------------------------------------------------------------
// caf_cordic: iterative CORDIC vectoring unit
// Computes atan2(y, x) in units of 2^-16 degree, one micro-rotation per cycle
// through a single shift-and-add stage.
// ----------------------------------------------------------------------------
module caf_cordic
    import caf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    output caf_unit_stat_t       stat,
    output logic signed [ZW-1:0] z_out
);

    localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam logic [TIW-1:0] LAST = TIW'(STEPS - 1);

    typedef enum logic
    {
        C_IDLE,
        C_RUN
    } cstate_t;

    cstate_t               state_reg;
    logic                  done_reg;
    logic [TIW-1:0]        i_reg;
    logic signed [CW-1:0]  x_reg;
    logic signed [CW-1:0]  y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic signed [CW-1:0]  xs;
    logic signed [CW-1:0]  ys;

    // Arithmetic shifts round toward minus infinity.
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    // On the x axis the angle is known without rotating.
                    done_reg <= start && (y_in == '0);
                    if (start)
                    begin
                        i_reg <= '0;
                        priority if (y_in == '0)
                        begin
                            z_reg <= (x_in >= 0) ? '0 : DEG180;
                        end
                        else if (x_in < 0)
                        begin
                            // Left half-plane: mirror the vector and preload +180 or -180 degrees by the sign of y.
                            x_reg     <= -x_in;
                            y_reg     <= -y_in;
                            z_reg     <= (y_in > 0) ? DEG180 : -DEG180;
                            state_reg <= C_RUN;
                        end
                        else
                        begin
                            x_reg     <= x_in;
                            y_reg     <= y_in;
                            z_reg     <= '0;
                            state_reg <= C_RUN;
                        end
                    end
                end
                C_RUN:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_entry(i_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_entry(i_reg);
                    end
                    i_reg    <= i_reg + 1'b1;
                    done_reg <= (i_reg == LAST);
                    if (i_reg == LAST)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg == C_RUN);
    assign stat.done = done_reg;
    assign z_out     = z_reg;

endmodule

// ===== src/caf_isqrt.sv =====
// ----------------------------------------------------------------------------
// caf_isqrt: iterative integer square root
// Digit-by-digit restoring square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module caf_isqrt
    import caf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RAD_W-1:0]    n_in,
    output caf_unit_stat_t      stat,
    output logic [ROOT_W-1:0]   root_out
);

    localparam int KW = $clog2(ROOT_W);
    localparam logic [KW-1:0] K_TOP = KW'(ROOT_W - 1);

    typedef enum logic
    {
        Q_IDLE,
        Q_RUN
    } qstate_t;

    qstate_t            state_reg;
    logic               done_reg;
    logic [KW-1:0]      k_reg;
    logic [RAD_W-1:0]   rem_reg;
    logic [RAD_W-1:0]   res_reg;
    logic [RAD_W-1:0]   bit_val;
    logic [RAD_W-1:0]   trial;

    // Current trial bit is 4^k.
    assign bit_val = RAD_W'(1) << {k_reg, 1'b0};
    assign trial   = res_reg + bit_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
            rem_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                Q_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        rem_reg   <= n_in;
                        res_reg   <= '0;
                        k_reg     <= K_TOP;
                        state_reg <= Q_RUN;
                    end
                end
                Q_RUN:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_val;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    k_reg    <= k_reg - 1'b1;
                    done_reg <= (k_reg == '0);
                    if (k_reg == '0)
                    begin
                        state_reg <= Q_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= Q_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg == Q_RUN);
    assign stat.done = done_reg;
    assign root_out  = res_reg[ROOT_W-1:0];

endmodule

// ===== src/complementary_attitude_filter_top.sv =====
// ----------------------------------------------------------------------------
// complementary_attitude_filter_top: roll and pitch complementary filter
//
// Each input item is one IMU sample. For a valid sample the block forms the
// accelerometer roll atan2(ay, az) and pitch atan2(-ax, sqrt(ay^2 + az^2)) by
// CORDIC, removes the configured bias from each gyro rate, and updates each
// angle as 0.98 * (angle + rate * 0.01 s) + 0.02 * accel_angle, saturating at
// the 32-bit limits. Angles are in units of 2^-16 degree and rates in units of
// 2^-7 degrees per second. Every input item gives exactly one output item with
// the current roll and pitch estimates; a sample whose valid flag is clear
// leaves the estimates untouched. The block works on one item at a time and
// holds s_tready low until it is done. For a valid sample it squares and sums
// ay and az, starts the square root alongside the roll CORDIC pass (the CORDIC
// step count, 16 by default, is capped at 24), blends roll, waits for the
// root, and then runs the pitch CORDIC pass and its blend; an invalid sample
// goes straight to the result. One CORDIC unit, one square-root unit and one
// 34 x 20 multiplier are shared under the sequencer. The result sits in an
// output register, so the next item can be taken while the previous result
// waits on m_tready. The user must write the bias registers only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module complementary_attitude_filter_top
    import caf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input sample stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], rate_x [63:48],
    // rate_y [79:64]
    input  logic [79:0] s_tdata,
    // sample_valid [0]
    input  logic        s_tuser,
    // Output estimate stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // roll_angle_out [31:0], pitch_angle_out [63:32]
    output logic [63:0] m_tdata,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SQ_AY,
        S_SQ_AZ,
        S_MAG,
        S_RUN_ROLL,
        S_WAIT_ROLL,
        S_B_INC,
        S_B_SUM,
        S_B_ALPHA,
        S_B_BETA,
        S_B_FIN,
        S_WAIT_SQRT,
        S_RUN_PITCH,
        S_WAIT_PITCH,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic                   axis_reg;       // 0 while blending roll, 1 for pitch
    logic signed [15:0]     ax_reg;
    logic signed [15:0]     ay_reg;
    logic signed [15:0]     az_reg;
    logic signed [15:0]     gx_reg;
    logic signed [15:0]     gy_reg;
    logic signed [15:0]     roll_bias_reg;
    logic signed [15:0]     pitch_bias_reg;
    logic signed [31:0]     roll_est_reg;
    logic signed [31:0]     pitch_est_reg;
    logic [31:0]            mag_reg;
    logic signed [MP_W-1:0] prod_reg;
    logic signed [MP_W-1:0] part_reg;
    logic signed [33:0]     sum_reg;
    logic signed [ZW-1:0]   acc_reg;
    logic                   m_tvalid_reg;
    logic [63:0]            m_tdata_reg;

    // Shared multiplier.
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    // Shared iterative units.
    logic                   cr_start;
    logic signed [CW-1:0]   cr_x;
    logic signed [CW-1:0]   cr_y;
    caf_unit_stat_t         cr_stat;
    logic signed [ZW-1:0]   cr_z;
    logic                   sq_start;
    caf_unit_stat_t         sq_stat;
    logic [ROOT_W-1:0]      sq_root;

    // Blend datapath.
    logic signed [15:0]     rate_sel;
    logic signed [15:0]     bias_sel;
    logic signed [31:0]     est_sel;
    logic signed [16:0]     r_val;
    logic signed [MP_W-1:0] inc_full;
    logic signed [21:0]     inc_val;
    logic signed [MP_W:0]   total;
    logic signed [MP_W:0]   t_full;
    logic signed [31:0]     t_sat;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Per-axis selection for the blend.
    // ------------------------------------------------------------------
    assign rate_sel = axis_reg ? gy_reg : gx_reg;
    assign bias_sel = axis_reg ? pitch_bias_reg : roll_bias_reg;
    assign est_sel  = axis_reg ? pitch_est_reg : roll_est_reg;
    assign r_val    = 17'(rate_sel) - 17'(bias_sel);

    // Rate increment, rounded to nearest: r * 5.12 in units of 2^-16 degree.
    assign inc_full = (prod_reg + MP_W'(32768)) >>> 16;
    assign inc_val  = $signed(inc_full[21:0]);

    // Final blend of 0.98 * sum and 0.02 * acc, rounded, then saturated.
    assign total  = (MP_W + 1)'(part_reg) + (MP_W + 1)'(prod_reg) + (MP_W + 1)'(32768);
    assign t_full = total >>> 16;

    always_comb
    begin
        priority if (t_full > (MP_W + 1)'(64'sd2147483647))
        begin
            t_sat = 32'sh7FFF_FFFF;
        end
        else if (t_full < -(MP_W + 1)'(64'sd2147483648))
        begin
            t_sat = 32'sh8000_0000;
        end
        else
        begin
            t_sat = t_full[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Multiplier operand selection: one product per cycle, always registered.
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (state_reg)
            S_SQ_AY:
            begin
                mul_a = MA_W'(ay_reg);
                mul_b = MB_W'(ay_reg);
            end
            S_SQ_AZ:
            begin
                mul_a = MA_W'(az_reg);
                mul_b = MB_W'(az_reg);
            end
            S_B_INC:
            begin
                mul_a = MA_W'(r_val);
                mul_b = DT_RATE_Q16;
            end
            S_B_ALPHA:
            begin
                mul_a = sum_reg;
                mul_b = ALPHA_Q16;
            end
            S_B_BETA:
            begin
                mul_a = MA_W'(acc_reg);
                mul_b = BETA_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Shared CORDIC unit: roll first, then pitch against the root.
    // ------------------------------------------------------------------
    assign cr_start = (state_reg == S_RUN_ROLL) || (state_reg == S_RUN_PITCH);
    assign cr_x     = (state_reg == S_RUN_PITCH) ? CW'(sq_root) : (CW'(az_reg) <<< 14);
    assign cr_y     = (state_reg == S_RUN_PITCH) ? -(CW'(ax_reg) <<< 14)
                                                 : (CW'(ay_reg) <<< 14);

    caf_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cr_start),
        .x_in   (cr_x),
        .y_in   (cr_y),
        .stat   (cr_stat),
        .z_out  (cr_z)
    );

    // The square root of (ay^2 + az^2) * 2^28 runs alongside the roll pass.
    assign sq_start = (state_reg == S_RUN_ROLL);

    caf_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .n_in     ({mag_reg, 28'd0}),
        .stat     (sq_stat),
        .root_out (sq_root)
    );

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_bias_reg  <= '0;
            pitch_bias_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ROLL_BIAS:  roll_bias_reg  <= cfg_wdata;
                REG_PITCH_BIAS: pitch_bias_reg <= cfg_wdata;
                default:        roll_bias_reg  <= roll_bias_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer with its datapath and output registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            az_reg        <= '0;
            gx_reg        <= '0;
            gy_reg        <= '0;
            roll_est_reg  <= '0;
            pitch_est_reg <= '0;
            mag_reg       <= '0;
            prod_reg      <= '0;
            part_reg      <= '0;
            sum_reg       <= '0;
            acc_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            // A waiting result leaves once the sink takes it, unless a new
            // result replaces it on the same edge.
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        ax_reg    <= s_tdata[15:0];
                        ay_reg    <= s_tdata[31:16];
                        az_reg    <= s_tdata[47:32];
                        gx_reg    <= s_tdata[63:48];
                        gy_reg    <= s_tdata[79:64];
                        axis_reg  <= 1'b0;
                        state_reg <= s_tuser ? S_SQ_AY : S_DONE;
                    end
                end
                S_SQ_AY:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SQ_AZ;
                end
                S_SQ_AZ:
                begin
                    prod_reg  <= mul_p;
                    mag_reg   <= prod_reg[31:0];
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    mag_reg   <= mag_reg + prod_reg[31:0];
                    state_reg <= S_RUN_ROLL;
                end
                S_RUN_ROLL:
                begin
                    state_reg <= S_WAIT_ROLL;
                end
                S_WAIT_ROLL:
                begin
                    if (cr_stat.done)
                    begin
                        acc_reg   <= cr_z;
                        axis_reg  <= 1'b0;
                        state_reg <= S_B_INC;
                    end
                end
                S_B_INC:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_B_SUM;
                end
                S_B_SUM:
                begin
                    sum_reg   <= 34'(est_sel) + 34'(inc_val);
                    state_reg <= S_B_ALPHA;
                end
                S_B_ALPHA:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_B_BETA;
                end
                S_B_BETA:
                begin
                    part_reg  <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= S_B_FIN;
                end
                S_B_FIN:
                begin
                    if (axis_reg)
                    begin
                        pitch_est_reg <= t_sat;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        roll_est_reg <= t_sat;
                        state_reg    <= S_WAIT_SQRT;
                    end
                end
                S_WAIT_SQRT:
                begin
                    if (!sq_stat.busy)
                    begin
                        state_reg <= S_RUN_PITCH;
                    end
                end
                S_RUN_PITCH:
                begin
                    state_reg <= S_WAIT_PITCH;
                end
                S_WAIT_PITCH:
                begin
                    if (cr_stat.done)
                    begin
                        acc_reg   <= cr_z;
                        axis_reg  <= 1'b1;
                        state_reg <= S_B_INC;
                    end
                end
                S_DONE:
                begin
                    // Hand the estimates to the output register once it is free.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {pitch_est_reg, roll_est_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The CORDIC unit only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cr_stat.done |-> (state_reg == S_WAIT_ROLL || state_reg == S_WAIT_PITCH))
        else $error("CORDIC finished outside a wait state");

    // The pitch pass never starts on a root that is still being formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN_PITCH) |-> !sq_stat.busy)
        else $error("pitch CORDIC started while the square root was busy");

    // A sample flagged invalid goes straight to the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> (state_reg == S_DONE))
        else $error("invalid sample entered the arithmetic sequence");

    // The estimates change only at the end of a blend.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(roll_est_reg) || !$stable(pitch_est_reg)) |-> ($past(state_reg) == S_B_FIN))
        else $error("estimate changed outside the blend step");
`endif

endmodule
